// ----- rtl/core/midpoint_line_raster_assert.svh -----
// ----------------------------------------------------------------------------
// midpoint_line_raster assertion macros
// Shared concurrent assertion wrappers for the line rasterizer checkers.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTER_ASSERT_SVH
`define MIDPOINT_LINE_RASTER_ASSERT_SVH

// Assertion clocked on clk, inactive while rst is high.
`define MLR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("midpoint_line_raster assertion failed");

// Assertion clocked on clk that also holds through reset.
`define MLR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("midpoint_line_raster assertion failed");

`endif

// ----- rtl/core/mlr_pkg.sv -----
// ----------------------------------------------------------------------------
// mlr_pkg
// Types and constants shared by the midpoint line rasterizer modules.
// ----------------------------------------------------------------------------
package mlr_pkg;

   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 24;
   localparam int DEC_BITS   = COORD_BITS + 5;
   localparam int INC_BITS   = COORD_BITS + 4;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [COLOR_BITS-1:0]      color_type;
   typedef logic signed [DEC_BITS-1:0] dec_type;
   typedef logic signed [INC_BITS-1:0] inc_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

   // Line case: which axis is major and which way the minor axis moves.
   typedef enum logic [1:0] {
      OCT_X_MAJOR_RISE = 2'd0,
      OCT_Y_MAJOR_RISE = 2'd1,
      OCT_X_MAJOR_FALL = 2'd2,
      OCT_Y_MAJOR_FALL = 2'd3
   } octant_type;

   typedef struct packed {
      action_type action;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  end_x;
      coord_type  end_y;
      color_type  line_color;
   } req_type;

   typedef struct packed {
      logic      pixel_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      color_type pixel_color;
      logic      last_pixel;
   } rsp_type;

   typedef struct packed {
      coord_type  cur_x;
      coord_type  cur_y;
      coord_type  major_end;
      dec_type    decision;
      inc_type    inc_keep;
      inc_type    inc_step;
      octant_type octant;
      logic       active;
   } line_state_type;

endpackage

// ----- rtl/core/midpoint_line_raster.sv -----
// ----------------------------------------------------------------------------
// midpoint_line_raster
// Integer midpoint line rasterizer for all octants, one pixel per transaction.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready, req_type): a load transaction (action = load)
//    latches two endpoints and a color and returns the first pixel; a step
//    transaction returns the next pixel of the current line.
//  - rsp channel (valid/ready, rsp_type): exactly one response per request.
//    The line endpoint carries last_pixel. A step with no line in progress
//    (never loaded, or endpoint already sent) returns pixel_valid = 0 with
//    all other fields zero. Equal endpoints give one pixel flagged last.
//  - A load in the middle of a line drops the old line.
//  - The response is registered: rsp_valid rises in the cycle after acceptance.
//  - Throughput: one transaction per cycle when not stalled; setup or step
//    and endpoint compare run in the accept cycle; the output register sets the pace.
//  - Stall: while rsp_valid is high and rsp_ready is low, the response holds
//    and req_ready is low; req_ready follows rsp_ready combinationally.
//  - Reset (synchronous, active high) drops any line and any pending response.
// ----------------------------------------------------------------------------
module midpoint_line_raster (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mlr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mlr_pkg::rsp_type rsp_data
);
   import mlr_pkg::*;

   line_state_type line_ff, line_in;
   line_state_type setup_state, adv_state, pick;
   color_type      color_ff, color_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept, emit, last;
   coord_type      major;

   mlr_setup u_setup (
      .req   (req_data),
      .setup (setup_state)
   );

   mlr_advance u_advance (
      .cur (line_ff),
      .nxt (adv_state)
   );

   // Output register frees up whenever the consumer takes the pending pixel.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      line_in  = line_ff;
      color_in = color_ff;
      rsp_in   = '0;
      pick     = adv_state;
      emit     = 1'b0;

      priority if (req_data.action == ACT_LOAD) begin
         pick     = setup_state;
         color_in = req_data.line_color;
         emit     = 1'b1;
      end else if (line_ff.active) begin
         pick = adv_state;
         emit = 1'b1;
      end else begin
         emit = 1'b0;
      end

      // Endpoint test on the major axis of the new pixel.
      major = ((pick.octant == OCT_X_MAJOR_RISE) || (pick.octant == OCT_X_MAJOR_FALL))
            ? pick.cur_x : pick.cur_y;
      last  = (major == pick.major_end);

      if (emit) begin
         line_in            = pick;
         line_in.active     = !last;
         rsp_in.pixel_valid = 1'b1;
         rsp_in.pixel_x     = pick.cur_x;
         rsp_in.pixel_y     = pick.cur_y;
         rsp_in.pixel_color = color_in;
         rsp_in.last_pixel  = last;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) line_ff <= line_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         color_ff <= color_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/mlr_setup.sv -----
// ----------------------------------------------------------------------------
// mlr_setup
// Line setup: orders endpoints, classifies the case, builds decision terms.
// ----------------------------------------------------------------------------
module mlr_setup (
   input  mlr_pkg::req_type        req,
   output mlr_pkg::line_state_type setup
);
   import mlr_pkg::*;

   logic signed [COORD_BITS:0] dx_raw, dy_raw, adx, ady;
   logic signed [COORD_BITS:0] dx, dy;
   dec_type                    dxe, dye;
   dec_type                    dec, step_inc, keep_inc;
   logic                       same_sign, steep, swap;
   octant_type                 oct;
   coord_type                  x1, y1, x2, y2;

   always_comb begin
      dx_raw    = $signed({1'b0, req.end_x}) - $signed({1'b0, req.start_x});
      dy_raw    = $signed({1'b0, req.end_y}) - $signed({1'b0, req.start_y});
      adx       = dx_raw[COORD_BITS] ? -dx_raw : dx_raw;
      ady       = dy_raw[COORD_BITS] ? -dy_raw : dy_raw;
      same_sign = (dx_raw[COORD_BITS] == dy_raw[COORD_BITS]);
      steep     = (ady > adx);

      if (!steep) begin
         oct  = ((dy_raw == '0) || same_sign) ? OCT_X_MAJOR_RISE : OCT_X_MAJOR_FALL;
         swap = (req.start_x > req.end_x);
      end else begin
         oct  = same_sign ? OCT_Y_MAJOR_RISE : OCT_Y_MAJOR_FALL;
         swap = (req.start_y > req.end_y);
      end

      x1 = swap ? req.end_x   : req.start_x;
      y1 = swap ? req.end_y   : req.start_y;
      x2 = swap ? req.start_x : req.end_x;
      y2 = swap ? req.start_y : req.end_y;

      dx  = $signed({1'b0, x2}) - $signed({1'b0, x1});
      dy  = $signed({1'b0, y2}) - $signed({1'b0, y1});
      dxe = DEC_BITS'(dx);
      dye = DEC_BITS'(dy);

      unique case (oct)
         OCT_X_MAJOR_RISE: begin
            dec      = dxe - (dye <<< 1);
            step_inc = (dxe <<< 1) - (dye <<< 1);
            keep_inc = -(dye <<< 1);
         end
         OCT_Y_MAJOR_RISE: begin
            dec      = (dxe <<< 1) - dye;
            step_inc = (dxe - dye) <<< 1;
            keep_inc = dxe <<< 1;
         end
         OCT_X_MAJOR_FALL: begin
            dec      = -dxe - (dye <<< 1);
            step_inc = -((dxe + dye) <<< 1);
            keep_inc = -(dye <<< 1);
         end
         OCT_Y_MAJOR_FALL: begin
            dec      = (dxe <<< 1) + dye;
            step_inc = (dxe + dye) <<< 1;
            keep_inc = dxe <<< 1;
         end
      endcase

      setup.cur_x     = x1;
      setup.cur_y     = y1;
      setup.major_end = ((oct == OCT_X_MAJOR_RISE) || (oct == OCT_X_MAJOR_FALL)) ? x2 : y2;
      setup.decision  = dec;
      setup.inc_step  = INC_BITS'(step_inc);
      setup.inc_keep  = INC_BITS'(keep_inc);
      setup.octant    = oct;
      setup.active    = 1'b1;
   end

endmodule

// ----- rtl/core/mlr_advance.sv -----
// ----------------------------------------------------------------------------
// mlr_advance
// One midpoint step: major axis +1, minor axis by decision sign.
// ----------------------------------------------------------------------------
module mlr_advance (
   input  mlr_pkg::line_state_type cur,
   output mlr_pkg::line_state_type nxt
);
   import mlr_pkg::*;

   logic    dec_neg, dec_zero, step_minor;
   dec_type inc;

   always_comb begin
      dec_neg  = cur.decision[DEC_BITS-1];
      dec_zero = (cur.decision == '0);
      if ((cur.octant == OCT_X_MAJOR_RISE) || (cur.octant == OCT_Y_MAJOR_FALL)) begin
         step_minor = dec_neg || dec_zero;
      end else begin
         step_minor = !dec_neg;
      end
      inc = step_minor ? DEC_BITS'(cur.inc_step) : DEC_BITS'(cur.inc_keep);

      nxt          = cur;
      nxt.decision = cur.decision + inc;

      unique case (cur.octant)
         OCT_X_MAJOR_RISE: begin
            if (step_minor) nxt.cur_y = cur.cur_y + COORD_BITS'(1);
            nxt.cur_x = cur.cur_x + COORD_BITS'(1);
         end
         OCT_Y_MAJOR_RISE: begin
            if (step_minor) nxt.cur_x = cur.cur_x + COORD_BITS'(1);
            nxt.cur_y = cur.cur_y + COORD_BITS'(1);
         end
         OCT_X_MAJOR_FALL: begin
            if (step_minor) nxt.cur_y = cur.cur_y - COORD_BITS'(1);
            nxt.cur_x = cur.cur_x + COORD_BITS'(1);
         end
         OCT_Y_MAJOR_FALL: begin
            if (step_minor) nxt.cur_x = cur.cur_x - COORD_BITS'(1);
            nxt.cur_y = cur.cur_y + COORD_BITS'(1);
         end
      endcase
   end

endmodule

// ----- rtl/core/mlr_checker.sv -----
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks for the midpoint line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "midpoint_line_raster_assert.svh"

module mlr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mlr_pkg::rsp_type rsp_data
);
   import mlr_pkg::*;

   // A stalled response holds.
   `MLR_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))

   // An empty output register always takes a request.
   `MLR_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // Every accepted request shows up as a response on the next cycle.
   `MLR_ASSERT(a_rsp_after_req, clock, reset, (req_valid && req_ready) |=> rsp_valid)

   // A no-pixel response carries all-zero fields.
   `MLR_ASSERT(a_invalid_zero, clock, reset, (rsp_valid && !rsp_data.pixel_valid) |-> (rsp_data == '0))

   // Reset empties the output register.
   `MLR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind midpoint_line_raster mlr_checker u_mlr_checker (.*);
